// ----- hdl/tps_pkg.sv -----
// Package for the timed pattern sequencer: table geometry, opcodes, status codes,
// configuration register indexes, shared structs and helper functions.
// No dependencies.
package tps_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int DWELL_BITS  = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int VALUE_W     = 32;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_RESET = 3'd3,
        OP_WRITE = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_DWELL = 2'd1,
        ST_RANGE      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_START_INDEX    = 2'd0,
        CFG_ENTRIES_IN_USE = 2'd1,
        CFG_VALUE_BYTES    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]            opcode;
        logic [3:0]            entry_index;
        logic [VALUE_W-1:0]    entry_value;
        logic [DWELL_BITS-1:0] entry_dwell;
    } item_t;

    typedef struct packed {
        logic [3:0] start_index;
        logic [4:0] entries_in_use;
        logic [2:0] value_bytes;
    } cfg_t;

    typedef struct packed {
        logic                  en;
        logic [IDX_W-1:0]      idx;
        logic [VALUE_W-1:0]    value;
        logic [DWELL_BITS-1:0] dwell;
    } tbl_wr_t;

    typedef struct packed {
        logic [VALUE_W-1:0] drive_value;
        logic               drive_strobe;
        logic [3:0]         current_entry;
        status_t            status;
    } result_t;

    function automatic logic [CNT_W-1:0] eff_count(input logic [4:0] n);
        logic [31:0] n32;
        n32 = 32'(n);
        if (n32 == 32'd0) begin
            return CNT_W'(1);
        end
        if (n32 > 32'(TABLE_DEPTH)) begin
            return CNT_W'(TABLE_DEPTH);
        end
        return CNT_W'(n32);
    endfunction

    function automatic logic [VALUE_W-1:0] value_mask(input logic [2:0] bytes);
        logic [VALUE_W-1:0] m;
        case (bytes)
            3'd0, 3'd1: m = 32'h0000_00FF;
            3'd2:       m = 32'h0000_FFFF;
            3'd3:       m = 32'h00FF_FFFF;
            default:    m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// ----- hdl/tps_table.sv -----
// Pattern table: value and dwell entries with one write port and one read port.
// Depends on tps_pkg.
module tps_table (
    input  logic                           clk,
    input  tps_pkg::tbl_wr_t               wr,
    input  logic [tps_pkg::IDX_W-1:0]      rd_addr,
    output logic [tps_pkg::VALUE_W-1:0]    rd_value,
    output logic [tps_pkg::DWELL_BITS-1:0] rd_dwell
);
    import tps_pkg::*;

    logic [VALUE_W-1:0]    value_reg [TABLE_DEPTH];
    logic [DWELL_BITS-1:0] dwell_reg [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            value_reg[wr.idx] <= wr.value;
            dwell_reg[wr.idx] <= wr.dwell;
        end
    end

    // forward a write that lands on the entry being read
    always_comb
    begin
        if (wr.en && (wr.idx == rd_addr))
        begin
            rd_value = wr.value;
            rd_dwell = wr.dwell;
        end
        else
        begin
            rd_value = value_reg[rd_addr];
            rd_dwell = dwell_reg[rd_addr];
        end
    end

endmodule

// ----- hdl/tps_ctrl.sv -----
// Sequencer state and per-word decision logic: active entry, dwell count,
// run flag, driven value. Depends on tps_pkg and tps_table.
module tps_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  tps_pkg::item_t   item,
    input  tps_pkg::cfg_t    cfg,
    output tps_pkg::result_t res
);
    import tps_pkg::*;

    logic [IDX_W-1:0]      active_reg, active_next;
    logic [DWELL_BITS-1:0] dwell_reg, dwell_next;
    logic                  running_reg, running_next;
    logic [VALUE_W-1:0]    driven_reg, driven_next;

    logic [CNT_W-1:0]      count;
    logic                  start_ok;
    logic                  widx_ok;
    logic [CNT_W-1:0]      inc_idx;
    logic [IDX_W-1:0]      wrap_idx;
    logic [IDX_W-1:0]      rd_addr;
    logic [VALUE_W-1:0]    rd_value;
    logic [DWELL_BITS-1:0] rd_dwell;
    logic                  load;
    logic                  redrive;
    logic                  strobe;
    status_t               status;
    tbl_wr_t               wr;

    tps_table u_table (
        .clk      (clk),
        .wr       (wr),
        .rd_addr  (rd_addr),
        .rd_value (rd_value),
        .rd_dwell (rd_dwell)
    );

    assign count    = eff_count(cfg.entries_in_use);
    assign start_ok = 32'(cfg.start_index) < 32'(count);
    assign widx_ok  = 32'(item.entry_index) < 32'(count);
    assign inc_idx  = CNT_W'(active_reg) + CNT_W'(1);
    assign wrap_idx = (inc_idx >= count) ? '0 : IDX_W'(inc_idx);

    always_comb
    begin
        rd_addr      = active_reg;
        load         = 1'b0;
        redrive      = 1'b0;
        running_next = running_reg;
        status       = ST_OK;
        wr.en        = 1'b0;
        wr.idx       = IDX_W'(item.entry_index);
        wr.value     = item.entry_value;
        wr.dwell     = item.entry_dwell;
        dwell_next   = dwell_reg;
        case (item.opcode)
            OP_TICK:
            begin
                if (running_reg)
                begin
                    if (dwell_reg <= DWELL_BITS'(1))
                    begin
                        rd_addr = wrap_idx;
                        load    = 1'b1;
                    end
                    else
                    begin
                        dwell_next = dwell_reg - DWELL_BITS'(1);
                    end
                end
            end
            OP_START, OP_RESET:
            begin
                if (!start_ok)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    rd_addr = IDX_W'(cfg.start_index);
                    load    = 1'b1;
                    if (item.opcode == OP_START)
                    begin
                        running_next = 1'b1;
                    end
                end
            end
            OP_STOP:
            begin
                running_next = 1'b0;
            end
            OP_WRITE:
            begin
                if (!widx_ok)
                begin
                    status = ST_RANGE;
                end
                else if (item.entry_dwell == '0)
                begin
                    status = ST_ZERO_DWELL;
                end
                else
                begin
                    wr.en = fire;
                    if (running_reg)
                    begin
                        redrive = 1'b1;
                    end
                    else if (start_ok)
                    begin
                        rd_addr = IDX_W'(cfg.start_index);
                        load    = 1'b1;
                    end
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        active_next = active_reg;
        driven_next = driven_reg;
        strobe      = 1'b0;
        if (load)
        begin
            active_next = rd_addr;
            driven_next = rd_value & value_mask(cfg.value_bytes);
            strobe      = 1'b1;
        end
        else if (redrive)
        begin
            driven_next = rd_value & value_mask(cfg.value_bytes);
            strobe      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= '0;
            dwell_reg   <= '0;
            running_reg <= 1'b0;
            driven_reg  <= '0;
        end
        else if (fire)
        begin
            active_reg  <= active_next;
            dwell_reg   <= load ? rd_dwell : dwell_next;
            running_reg <= running_next;
            driven_reg  <= driven_next;
        end
    end

    assign res.drive_value   = driven_next;
    assign res.drive_strobe  = strobe;
    assign res.current_entry = 4'(active_next);
    assign res.status        = status;

endmodule

// ----- hdl/timed_pattern_sequencer.sv -----
// Top level of the timed pattern sequencer: input word register, configuration
// registers, result register and handshakes. Depends on tps_pkg and tps_ctrl.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  in      | in        | in_valid / in_stall    | opcode, entry_index, entry_value,
//          |           |                        | entry_dwell
//  out     | out       | out_valid / out_stall  | drive_value, drive_strobe,
//          |           |                        | current_entry, status
//  cfg     | in        | cfg_write_en           | cfg_index, cfg_data
//
// One word per cycle sustained while out_stall is low. A word accepted into the input
// register is worked on from there, and its result is loaded into the result register
// when the word fires; the table read is combinational and adds no register.
// Reset clears the sequencer state, resets configuration; table contents stay unknown.
// out_stall holds a valid result register and, once the input register is full, in_stall.
module timed_pattern_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     opcode,
    input  logic [3:0]                     entry_index,
    input  logic [tps_pkg::VALUE_W-1:0]    entry_value,
    input  logic [tps_pkg::DWELL_BITS-1:0] entry_dwell,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tps_pkg::VALUE_W-1:0]    drive_value,
    output logic                           drive_strobe,
    output logic [3:0]                     current_entry,
    output logic [1:0]                     status,
    input  logic                           cfg_write_en,
    input  logic [1:0]                     cfg_index,
    input  logic [4:0]                     cfg_data
);
    import tps_pkg::*;

    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t res;
    cfg_t    cfg_reg;
    logic    advance;
    logic    fire;
    logic    accept;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_index    <= 4'd0;
            cfg_reg.entries_in_use <= 5'd1;
            cfg_reg.value_bytes    <= 3'd4;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_START_INDEX:    cfg_reg.start_index    <= cfg_data[3:0];
                CFG_ENTRIES_IN_USE: cfg_reg.entries_in_use <= cfg_data;
                CFG_VALUE_BYTES:    cfg_reg.value_bytes    <= cfg_data[2:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.opcode      <= opcode;
            item_reg.entry_index <= entry_index;
            item_reg.entry_value <= entry_value;
            item_reg.entry_dwell <= entry_dwell;
        end
    end

    tps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_value   = out_reg.drive_value;
    assign drive_strobe  = out_reg.drive_strobe;
    assign current_entry = out_reg.current_entry;
    assign status        = out_reg.status;

    a_strobe_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_strobe |-> status == ST_OK)
        else $error("strobe raised on a refused word");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with room to advance");

    a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("processed word produced no result");

endmodule

// ----- tb/timed_pattern_sequencer_tb.sv -----
// Self-checking testbench for the timed pattern sequencer: directed words, then random
// traffic under several register settings, checked against an in-bench predictor.
// Depends on tps_pkg and timed_pattern_sequencer.
module timed_pattern_sequencer_tb;
    import tps_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PHASES_PER_MODE = 5;
    localparam int WORDS_PER_PHASE = 100;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic [2:0]            opcode       = 3'(OP_TICK);
    logic [3:0]            entry_index  = '0;
    logic [VALUE_W-1:0]    entry_value  = '0;
    logic [DWELL_BITS-1:0] entry_dwell  = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [VALUE_W-1:0]    drive_value;
    logic                  drive_strobe;
    logic [3:0]            current_entry;
    logic [1:0]            status;
    logic                  cfg_write_en = 1'b0;
    logic [1:0]            cfg_index    = 2'(CFG_START_INDEX);
    logic [4:0]            cfg_data     = '0;

    // predictor state
    logic [VALUE_W-1:0]    seq_value [TABLE_DEPTH];
    logic [DWELL_BITS-1:0] seq_dwell [TABLE_DEPTH];
    logic [3:0]            seq_index   = '0;
    logic [DWELL_BITS-1:0] seq_left    = '0;
    logic                  seq_running = 1'b0;
    logic [VALUE_W-1:0]    seq_driven  = '0;
    logic [3:0]            cfg_start   = 4'd0;
    logic [4:0]            cfg_entries = 5'd1;
    logic [2:0]            cfg_bytes   = 3'd4;

    result_t due_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int failures      = 0;
    int words_sent    = 0;
    int settings_used = 0;
    int refusals      = 0;
    int strobes       = 0;
    int stuck_cycles  = 0;

    timed_pattern_sequencer dut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int entry_count(input logic [4:0] n);
        int c;
        c = int'(n);
        if (c == 0) c = 1;
        if (c > TABLE_DEPTH) c = TABLE_DEPTH;
        return c;
    endfunction

    function automatic logic [VALUE_W-1:0] byte_masked(input logic [VALUE_W-1:0] v);
        int nb;
        nb = (cfg_bytes == 3'd0) ? 1 : int'(cfg_bytes);
        if (nb >= 4) return v;
        return v & ~(32'hFFFF_FFFF << (8 * nb));
    endfunction

    function automatic void activate(input logic [3:0] i);
        seq_index  = i;
        seq_driven = byte_masked(seq_value[i]);
        seq_left   = seq_dwell[i];
    endfunction

    function automatic result_t sequencer_step(input logic [2:0] op, input logic [3:0] idx,
                                               input logic [VALUE_W-1:0] val,
                                               input logic [DWELL_BITS-1:0] dw);
        result_t r;
        int      cnt;
        int      nxt;
        logic    strobe;
        status_t st;
        cnt    = entry_count(cfg_entries);
        strobe = 1'b0;
        st     = ST_OK;
        case (op)
            OP_TICK:
            begin
                if (seq_running)
                begin
                    if (seq_left <= 1)
                    begin
                        nxt = int'(seq_index) + 1;
                        if (nxt >= cnt) nxt = 0;
                        activate(4'(nxt));
                        strobe = 1'b1;
                    end
                    else
                    begin
                        seq_left = seq_left - 1;
                    end
                end
            end
            OP_START, OP_RESET:
            begin
                if (int'(cfg_start) >= cnt)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    activate(cfg_start);
                    strobe = 1'b1;
                    if (op == OP_START) seq_running = 1'b1;
                end
            end
            OP_STOP:
            begin
                seq_running = 1'b0;
            end
            OP_WRITE:
            begin
                if (int'(idx) >= cnt)
                begin
                    st = ST_RANGE;
                end
                else if (dw == '0)
                begin
                    st = ST_ZERO_DWELL;
                end
                else
                begin
                    seq_value[idx] = val;
                    seq_dwell[idx] = dw;
                    if (seq_running)
                    begin
                        seq_driven = byte_masked(seq_value[seq_index]);
                        strobe     = 1'b1;
                    end
                    else if (int'(cfg_start) < cnt)
                    begin
                        activate(cfg_start);
                        strobe = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (st != ST_OK) refusals++;
        if (strobe) strobes++;
        r.drive_value   = seq_driven;
        r.drive_strobe  = strobe;
        r.current_entry = seq_index;
        r.status        = st;
        return r;
    endfunction

    task automatic send_word(input logic [2:0] op, input logic [3:0] idx,
                             input logic [VALUE_W-1:0] val, input logic [DWELL_BITS-1:0] dw);
        result_t expected;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        entry_index <= idx;
        entry_value <= val;
        entry_dwell <= dw;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected    = sequencer_step(op, idx, val, dw);
        due_results = {due_results, expected};
        words_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [3:0] s, input logic [4:0] e, input logic [2:0] b);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_START_INDEX;
        cfg_data     <= 5'(s);
        @(posedge clk);
        cfg_index    <= CFG_ENTRIES_IN_USE;
        cfg_data     <= e;
        @(posedge clk);
        cfg_index    <= CFG_VALUE_BYTES;
        cfg_data     <= 5'(b);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        cfg_start   = s;
        cfg_entries = e;
        cfg_bytes   = b;
        settings_used++;
    endtask

    task automatic send_random_word();
        int                    r;
        int                    cnt;
        logic [2:0]            op;
        logic [3:0]            idx;
        logic [VALUE_W-1:0]    val;
        logic [DWELL_BITS-1:0] dw;
        cnt = entry_count(cfg_entries);
        r   = $urandom_range(99);
        op  = OP_TICK;
        idx = 4'($urandom_range(15));
        val = $urandom;
        dw  = $urandom;
        if (r >= 55 && r < 75)
        begin
            op = OP_WRITE;
            if ($urandom_range(4) != 0) idx = 4'($urandom_range(cnt - 1));
            r = $urandom_range(99);
            if (r < 85) dw = $urandom_range(1, 4);
            else if (r < 90) dw = '0;
            else if (r < 97) dw = $urandom_range(5, 40);
            r = 0;
        end
        else if (r >= 75 && r < 81) op = OP_START;
        else if (r >= 81 && r < 86) op = OP_STOP;
        else if (r >= 86 && r < 91) op = OP_RESET;
        else if (r >= 91 && r < 94) op = 3'(OP_WRITE) + 3'($urandom_range(1, 3));
        send_word(op, idx, val, dw);
    endtask

    task automatic test_table_load();
        logic [VALUE_W-1:0]    val;
        logic [DWELL_BITS-1:0] dw;
        apply_settings(4'd0, 5'd16, 3'd4);
        // entry 0 first so that every later load reads written entries only
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            val = (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'h0 : $urandom;
            dw  = (i == TABLE_DEPTH - 1) ? 32'hFFFF_FFFF : 32'(i % 3 + 1);
            send_word(OP_WRITE, 4'(i), val, dw);
        end
        wait_idle();
    endtask

    task automatic test_stepping();
        send_word(OP_TICK, 4'd0, 32'h0, 32'h0);
        send_word(OP_START, 4'd0, 32'h0, 32'h0);
        send_word(OP_TICK, 4'd0, 32'h0, 32'h0);
        send_word(OP_TICK, 4'd0, 32'h0, 32'h0);
        send_word(OP_TICK, 4'd0, 32'h0, 32'h0);
        send_word(OP_START, 4'd0, 32'h0, 32'h0);
        send_word(OP_WRITE, 4'd5, $urandom, 32'd2);
        send_word(OP_STOP, 4'd0, 32'h0, 32'h0);
        send_word(OP_TICK, 4'd0, 32'h0, 32'h0);
        send_word(OP_RESET, 4'd0, 32'h0, 32'h0);
        send_word(3'(OP_WRITE) + 3'd3, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();
    endtask

    task automatic test_refusals();
        send_word(OP_WRITE, 4'd3, $urandom, 32'h0);
        wait_idle();
        apply_settings(4'd2, 5'd2, 3'd1);
        send_word(OP_START, 4'd0, 32'h0, 32'h0);
        send_word(OP_RESET, 4'd0, 32'h0, 32'h0);
        send_word(OP_WRITE, 4'd3, $urandom, 32'd3);
        send_word(OP_WRITE, 4'd1, $urandom, 32'd3);
        wait_idle();
    endtask

    task automatic test_shrunk_count();
        apply_settings(4'd9, 5'd16, 3'd4);
        send_word(OP_START, 4'd0, 32'h0, 32'h0);
        wait_idle();
        apply_settings(4'd0, 5'd2, 3'd4);
        send_word(OP_TICK, 4'd0, 32'h0, 32'h0);
        wait_idle();
    endtask

    task automatic test_byte_width();
        apply_settings(4'd0, 5'd0, 3'd0);
        send_word(OP_START, 4'd0, 32'h0, 32'h0);
        send_word(OP_TICK, 4'd0, 32'h0, 32'h0);
        wait_idle();
        apply_settings(4'd0, 5'd31, 3'd7);
        send_word(OP_RESET, 4'd0, 32'h0, 32'h0);
        send_word(OP_STOP, 4'd0, 32'h0, 32'h0);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int phase);
        logic [3:0] s;
        logic [4:0] e;
        logic [2:0] b;
        case (phase / PHASES_PER_MODE)
            0:       begin send_idle_pct = 18; recv_idle_pct = 53; end
            1:       begin send_idle_pct = 53; recv_idle_pct = 18; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        endcase
        case (phase)
            0:       begin s = 4'd0;  e = 5'd16; b = 3'd4; end
            1:       begin s = 4'd15; e = 5'd16; b = 3'd1; end
            2:       begin s = 4'd3;  e = 5'd0;  b = 3'd2; end
            3:       begin s = 4'd0;  e = 5'd31; b = 3'd0; end
            4:       begin s = 4'd9;  e = 5'd5;  b = 3'd7; end
            5:       begin s = 4'd2;  e = 5'd3;  b = 3'd3; end
            default:
            begin
                e = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 16));
                s = 4'($urandom_range(15));
                if ($urandom_range(4) != 0) s = 4'($urandom_range(entry_count(e) - 1));
                b = 3'($urandom_range(7));
            end
        endcase
        apply_settings(s, e, b);
        send_word(OP_START, 4'($urandom_range(15)), $urandom, $urandom);
        for (int i = 0; i < WORDS_PER_PHASE; i++)
        begin
            // hold the sender until the pipe has emptied
            if (phase % PHASES_PER_MODE == 2 && i == WORDS_PER_PHASE / 2) wait_idle();
            send_random_word();
        end
        wait_idle();
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $error("result word with nothing expected");
                failures++;
            end
            else
            begin
                want = due_results.pop_front();
                if (drive_value !== want.drive_value)
                begin
                    $error("drive_value: expected %h, got %h", want.drive_value, drive_value);
                    failures++;
                end
                if (drive_strobe !== want.drive_strobe)
                begin
                    $error("drive_strobe: expected %0d, got %0d", want.drive_strobe, drive_strobe);
                    failures++;
                end
                if (current_entry !== want.current_entry)
                begin
                    $error("current_entry: expected %0d, got %0d",
                           want.current_entry, current_entry);
                    failures++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    failures++;
                end
            end
        end
        out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
            else stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_load();
        test_stepping();
        test_refusals();
        test_shrunk_count();
        test_byte_width();
        for (int p = 0; p < 3 * PHASES_PER_MODE; p++) test_random_traffic(p);
        repeat (10) @(posedge clk);
        if (due_results.size() != 0)
        begin
            $error("%0d result words never arrived", due_results.size());
            failures++;
        end
        $display("ran %0d words through %0d register settings under three idling patterns",
                 words_sent, settings_used);
        $display("%0d values applied, %0d words refused, %0d mismatches",
                 strobes, refusals, failures);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
